>>> sv/orma_pkg.sv
// Shared types and constants of the outlier-rejecting moving average.
// No dependencies; used by the interfaces, the divider and the top level.
`timescale 1ns / 1ps
`default_nettype none
package orma_pkg;

  // Fixed field widths of the channels and the register.
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned AVG_W    = 12;
  localparam int unsigned THR_W    = 12;

  // Configuration port.
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_THRESH = '0;
  localparam logic [THR_W-1:0]   THRESH_RST = '1;

  // Divider handshake status.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

>>> sv/orma_if.sv
// Valid/ready channels for the sample items and the result items.
// Depends on orma_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none
interface orma_smp_if;
  logic                           valid;
  logic                           ready;
  logic [orma_pkg::SAMPLE_W-1:0]  sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface orma_res_if;
  logic                         valid;
  logic                         ready;
  logic [orma_pkg::AVG_W-1:0]   average;
  logic                         accepted;

  modport source (output valid, output average, output accepted, input ready);
  modport sink   (input valid, input average, input accepted, output ready);
endinterface
`default_nettype wire

>>> sv/orma_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module orma_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> sv/orma_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on orma_pkg for the status struct.
`timescale 1ns / 1ps
`default_nettype none
module orma_div #(
  parameter int unsigned NUM_W = 15,
  parameter int unsigned DEN_W = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [NUM_W-1:0]    num_i,
  input  wire logic [DEN_W-1:0]    den_i,
  output orma_pkg::div_stat_t      stat_o,
  output logic      [NUM_W-1:0]    quot_o
);

  localparam int unsigned CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] acc_q;   // dividend shifts out, quotient shifts in
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [DEN_W:0]   trial;
  logic             ge;
  logic [DEN_W:0]   diff;
  logic [DEN_W-1:0] rem_d;
  logic [NUM_W-1:0] acc_d;

  always_comb begin
    trial = {rem_q, acc_q[NUM_W-1]};
    ge    = trial >= {1'b0, den_q};
    diff  = trial - {1'b0, den_q};
    // remainder stays below the divisor, so it fits DEN_W bits
    rem_d = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    acc_d = {acc_q[NUM_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
      rem_q <= rem_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = acc_q;

endmodule
`default_nettype wire

>>> sv/outlier_rejecting_moving_average_core.sv
// Moving average over the last WINDOW accepted samples with outlier rejection.
// Once two samples have been accepted, a sample farther than reject_threshold
// from the current average is rejected, leaves the state alone and the result
// repeats the old average with accepted low. An accepted item passes through
// S_READ (once the window is full), S_UPDATE, S_DIVIDE and S_FINISH; a rejected
// one goes straight to S_FINISH. The average comes from a bit-serial divider of
// sum by count, SUM_W = SAMPLE_BITS + clog2(WINDOW) bits wide, 15 by default.
// Input is taken again as soon as the previous item is through, even if its
// result has not been taken yet. reject_threshold sits at byte address 0.
// Depends on orma_pkg, orma_if, orma_ram and orma_div.
`timescale 1ns / 1ps
`default_nettype none
module outlier_rejecting_moving_average_core #(
  parameter int unsigned WINDOW      = 8,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  orma_smp_if.sink                             smp_i,
  orma_res_if.source                           res_o,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [orma_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [orma_pkg::PDATA_W-1:0]    pwdata,
  output logic      [orma_pkg::PDATA_W-1:0]    prdata,
  output logic                                 pready
);

  localparam int unsigned IDX_W = $clog2(WINDOW);
  localparam int unsigned CNT_W = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W = SAMPLE_BITS + IDX_W;
  localparam int unsigned CMP_W =
      (SAMPLE_BITS > orma_pkg::THR_W) ? SAMPLE_BITS : orma_pkg::THR_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_UPDATE,
    S_DIVIDE,
    S_FINISH
  } state_e;

  state_e                       state_q;
  logic [orma_pkg::THR_W-1:0]   thr_q;
  logic [SAMPLE_BITS-1:0]       smp_q;
  logic [SAMPLE_BITS-1:0]       avg_q;
  logic [SUM_W-1:0]             sum_q;
  logic [SUM_W-1:0]             sum_d;
  logic [CNT_W-1:0]             fill_q;
  logic [CNT_W-1:0]             fill_d;
  logic [IDX_W-1:0]             widx_q;
  logic [IDX_W-1:0]             widx_nxt;
  logic                         take_q;
  logic                         ovalid_q;
  logic [orma_pkg::AVG_W-1:0]   oavg_q;
  logic                         oacc_q;

  logic [SAMPLE_BITS-1:0]       s_in;
  logic [SAMPLE_BITS-1:0]       gap;
  logic                         reject;
  logic                         full;
  logic                         in_fire;
  logic                         reg_wr;
  logic                         reg_hit;

  logic [SAMPLE_BITS-1:0]       old_smp;
  logic                         div_start;
  orma_pkg::div_stat_t          div_stat;
  logic [SUM_W-1:0]             quot;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign reg_hit = paddr[orma_pkg::PADDR_W-1:2] == orma_pkg::REG_THRESH;
  assign reg_wr  = psel && penable && pwrite && reg_hit;
  assign prdata  = reg_hit ? orma_pkg::PDATA_W'(thr_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= orma_pkg::THRESH_RST;
    end else if (reg_wr) begin
      thr_q <= pwdata[orma_pkg::THR_W-1:0];
    end
  end

  // ---------------- datapath ----------------
  assign s_in     = SAMPLE_BITS'(smp_i.sample);
  assign gap      = (s_in >= avg_q) ? (s_in - avg_q) : (avg_q - s_in);
  assign reject   = (fill_q > CNT_W'(1)) && (CMP_W'(gap) > CMP_W'(thr_q));
  assign full     = fill_q == CNT_W'(WINDOW);
  assign in_fire  = smp_i.valid && smp_i.ready;
  assign widx_nxt = (widx_q == IDX_W'(WINDOW - 1)) ? '0 : widx_q + IDX_W'(1);

  always_comb begin
    // oldest sample drops out only once the window is full
    sum_d  = sum_q + SUM_W'(smp_q) - (full ? SUM_W'(old_smp) : '0);
    fill_d = full ? fill_q : fill_q + CNT_W'(1);
  end

  assign div_start = state_q == S_UPDATE;

  orma_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (state_q == S_UPDATE),
    .waddr_i (widx_q),
    .wdata_i (smp_q),
    .re_i    (state_q == S_READ),
    .raddr_i (widx_q),
    .rdata_o (old_smp)
  );

  orma_div #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (sum_d),
    .den_i   (fill_d),
    .stat_o  (div_stat),
    .quot_o  (quot)
  );

  // ---------------- sequencer ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      avg_q    <= '0;
      sum_q    <= '0;
      fill_q   <= '0;
      widx_q   <= IDX_W'(WINDOW - 1);
      take_q   <= 1'b0;
      ovalid_q <= 1'b0;
      oacc_q   <= 1'b0;
    end else begin
      // S_FINISH reloads the output register itself
      if (ovalid_q && res_o.ready && state_q != S_FINISH) begin
        ovalid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            take_q <= !reject;
            if (reject) begin
              state_q <= S_FINISH;
            end else begin
              widx_q  <= widx_nxt;
              state_q <= full ? S_READ : S_UPDATE;
            end
          end
        end
        S_READ: begin
          state_q <= S_UPDATE;
        end
        S_UPDATE: begin
          sum_q   <= sum_d;
          fill_q  <= fill_d;
          state_q <= S_DIVIDE;
        end
        S_DIVIDE: begin
          if (div_stat.done) begin
            avg_q   <= SAMPLE_BITS'(quot);
            state_q <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!ovalid_q || res_o.ready) begin
            ovalid_q <= 1'b1;
            oacc_q   <= take_q;
            state_q  <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      smp_q <= s_in;
    end
    if (state_q == S_FINISH && (!ovalid_q || res_o.ready)) begin
      oavg_q <= orma_pkg::AVG_W'(avg_q);
    end
  end

  assign smp_i.ready    = state_q == S_IDLE;
  assign res_o.valid    = ovalid_q;
  assign res_o.average  = oavg_q;
  assign res_o.accepted = oacc_q;

endmodule
`default_nettype wire
